// ===== rtl/half_pel_motion_comp_top_macros.svh =====
// assertion macros for the half-pel motion compensation block
// used by half_pel_motion_comp_top only
`ifndef HALF_PEL_MOTION_COMP_TOP_MACROS_SVH
`define HALF_PEL_MOTION_COMP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HPMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpmc check failed");

// next-cycle implication, checked outside reset
`define HPMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpmc check failed");

`endif

// ===== rtl/hpmc_pkg.sv =====
// shared types and constants for the half-pel motion compensation block
// no dependencies
`timescale 1ns / 1ps

package hpmc_pkg;

   localparam int PIX_W = 8;

   // register indexes on the csr port
   localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd0;
   localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd1;
   localparam logic [1:0] REG_HALF_PEL     = 2'd2;
   localparam logic [1:0] REG_AVERAGE      = 2'd3;

   // half-pel modes
   localparam logic [1:0] MODE_COPY = 2'd0;
   localparam logic [1:0] MODE_HORZ = 2'd1;
   localparam logic [1:0] MODE_VERT = 2'd2;
   localparam logic [1:0] MODE_BOTH = 2'd3;

   localparam logic [4:0] BLOCK_WIDTH_RESET  = 5'd16;
   localparam logic [4:0] BLOCK_HEIGHT_RESET = 5'd16;

   typedef struct packed {
      logic [PIX_W-1:0] cur;
      logic [PIX_W-1:0] left;
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] above_left;
   } taps_type;

endpackage

// ===== rtl/hpmc_interp.sv =====
// interpolation and destination averaging for one prediction pixel
// depends on hpmc_pkg
`timescale 1ns / 1ps

module hpmc_interp
   import hpmc_pkg::*;
(
   input  taps_type         taps,
   input  logic [1:0]       mode,
   input  logic             average,
   input  logic [PIX_W-1:0] dest,
   output logic [PIX_W-1:0] pixel
);

   logic [PIX_W:0]   sum_h;
   logic [PIX_W:0]   sum_v;
   logic [PIX_W+1:0] sum_4;
   logic [PIX_W-1:0] interp;
   logic [PIX_W:0]   sum_d;

   always_comb begin
      sum_h = {1'b0, taps.left} + {1'b0, taps.cur} + (PIX_W+1)'(1);
      sum_v = {1'b0, taps.above} + {1'b0, taps.cur} + (PIX_W+1)'(1);
      sum_4 = {2'b00, taps.above_left} + {2'b00, taps.above}
            + {2'b00, taps.left} + {2'b00, taps.cur} + (PIX_W+2)'(2);
      unique case (mode)
         MODE_COPY: interp = taps.cur;
         MODE_HORZ: interp = sum_h[PIX_W:1];
         MODE_VERT: interp = sum_v[PIX_W:1];
         MODE_BOTH: interp = sum_4[PIX_W+1:2];
         default:   interp = taps.cur;
      endcase
      sum_d = {1'b0, interp} + {1'b0, dest} + (PIX_W+1)'(1);
      pixel = average ? sum_d[PIX_W:1] : interp;
   end

endmodule

// ===== rtl/half_pel_motion_comp_top.sv =====
// channel  | direction | tdata (low bit up)           | other
// req      | in        | ref_pixel, dest_pixel        | -
// rsp      | out       | pred_pixel                   | tlast = last_pixel
// csr      | apb       | 4 registers at 4*i           | pready tied high
//
// one item per cycle unless rsp stalls; each result goes through the tap stage, then the output register
// reset clears the line store, left and above-left taps, counters, valid flags and registers
// req_tready drops only when the tap stage and the output register are both full and rsp_tready is low
// with horizontal or vertical half-pel, items in the first window column or row update the taps and give no result
// depends on hpmc_pkg, hpmc_interp and the macros header
`timescale 1ns / 1ps

`include "half_pel_motion_comp_top_macros.svh"

module half_pel_motion_comp_top
   import hpmc_pkg::*;
#(
   parameter int MAX_BLOCK_WIDTH  = 16,
   parameter int MAX_BLOCK_HEIGHT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ref_pixel, dest_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pred_pixel
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ROW_DEPTH = MAX_BLOCK_WIDTH + 1;
   localparam int IW  = $clog2(ROW_DEPTH);
   localparam int CW  = $clog2(MAX_BLOCK_WIDTH + 2);
   localparam int RW  = $clog2(MAX_BLOCK_HEIGHT + 2);
   localparam int CMW = (CW > 5) ? CW : 5;
   localparam int CMH = (RW > 5) ? RW : 5;

   // registers
   logic [4:0] block_width_ff, block_width_in;
   logic [4:0] block_height_ff, block_height_in;
   logic [1:0] half_pel_ff, half_pel_in;
   logic       average_ff, average_in;

   // window state
   logic [PIX_W-1:0] row_store_ff [ROW_DEPTH];
   logic [PIX_W-1:0] left_ff, left_in;
   logic [PIX_W-1:0] above_left_ff, above_left_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;

   // tap stage
   logic             s1_valid_ff, s1_valid_in;
   taps_type         s1_taps_ff, s1_taps_in;
   logic [PIX_W-1:0] s1_dest_ff, s1_dest_in;
   logic             s1_last_ff, s1_last_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pix_ff, rsp_pix_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             cfg_wr;
   logic [1:0]       cfg_idx;
   logic             restart;
   logic             accept;
   logic             s1_go;
   logic             hx, hy;
   logic [CMW-1:0]   bw_ext;
   logic [CMH-1:0]   bh_ext;
   logic [CW-1:0]    eff_w, win_w, col_plus;
   logic [RW-1:0]    eff_h, win_h, row_plus;
   logic             col_end, row_end;
   logic             emit;
   logic [IW-1:0]    col_idx;
   logic [PIX_W-1:0] cur_pix, dest_pix, above_pix;
   logic [PIX_W-1:0] pix_out;

   // csr port
   assign csr_pready = 1'b1;
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_idx = csr_paddr[3:2];

   always_comb begin
      block_width_in  = block_width_ff;
      block_height_in = block_height_ff;
      half_pel_in     = half_pel_ff;
      average_in      = average_ff;
      restart         = 1'b0;
      if (cfg_wr) begin
         unique case (cfg_idx)
            REG_BLOCK_WIDTH: begin
               block_width_in = csr_pwdata[4:0];
               restart = 1'b1;
            end
            REG_BLOCK_HEIGHT: begin
               block_height_in = csr_pwdata[4:0];
               restart = 1'b1;
            end
            REG_HALF_PEL: begin
               half_pel_in = csr_pwdata[1:0];
               restart = 1'b1;
            end
            REG_AVERAGE: average_in = csr_pwdata[0];
            default: average_in = average_ff;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_BLOCK_WIDTH:  csr_prdata = {27'd0, block_width_ff};
         REG_BLOCK_HEIGHT: csr_prdata = {27'd0, block_height_ff};
         REG_HALF_PEL:     csr_prdata = {30'd0, half_pel_ff};
         REG_AVERAGE:      csr_prdata = {31'd0, average_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // window geometry
   assign hx     = half_pel_ff[0];
   assign hy     = half_pel_ff[1];
   assign bw_ext = CMW'(block_width_ff);
   assign bh_ext = CMH'(block_height_ff);

   always_comb begin
      if (bw_ext == '0) begin
         eff_w = CW'(1);
      end else if (bw_ext > CMW'(MAX_BLOCK_WIDTH)) begin
         eff_w = CW'(MAX_BLOCK_WIDTH);
      end else begin
         eff_w = CW'(bw_ext);
      end
      if (bh_ext == '0) begin
         eff_h = RW'(1);
      end else if (bh_ext > CMH'(MAX_BLOCK_HEIGHT)) begin
         eff_h = RW'(MAX_BLOCK_HEIGHT);
      end else begin
         eff_h = RW'(bh_ext);
      end
   end

   assign win_w    = eff_w + CW'(hx);
   assign win_h    = eff_h + RW'(hy);
   assign col_plus = col_ff + CW'(1);
   assign row_plus = row_ff + RW'(1);
   assign col_end  = col_plus >= win_w;
   assign row_end  = row_plus >= win_h;
   assign emit     = (col_ff >= CW'(hx)) && (row_ff >= RW'(hy));
   assign col_idx  = col_ff[IW-1:0];

   assign cur_pix   = req_tdata[7:0];
   assign dest_pix  = req_tdata[15:8];
   assign above_pix = row_store_ff[col_idx];

   // handshake
   assign s1_go      = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      left_in       = left_ff;
      above_left_in = above_left_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      if (accept) begin
         left_in       = cur_pix;
         above_left_in = above_pix;
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_plus;
         end else begin
            col_in = col_plus;
         end
      end
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_taps_in  = s1_taps_ff;
      s1_dest_in  = s1_dest_ff;
      s1_last_in  = s1_last_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (accept && emit) begin
         s1_valid_in           = 1'b1;
         s1_taps_in.cur        = cur_pix;
         s1_taps_in.left       = left_ff;
         s1_taps_in.above      = above_pix;
         s1_taps_in.above_left = above_left_ff;
         s1_dest_in            = dest_pix;
         s1_last_in            = col_end && row_end;
      end
   end

   hpmc_interp u_interp (
      .taps    (s1_taps_ff),
      .mode    (half_pel_ff),
      .average (average_ff),
      .dest    (s1_dest_ff),
      .pixel   (pix_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_go) begin
         rsp_valid_in = s1_valid_ff;
         rsp_pix_in   = pix_out;
         rsp_last_in  = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_width_ff  <= BLOCK_WIDTH_RESET;
         block_height_ff <= BLOCK_HEIGHT_RESET;
         half_pel_ff     <= MODE_COPY;
         average_ff      <= 1'b0;
         left_ff         <= '0;
         above_left_ff   <= '0;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < ROW_DEPTH; i++) begin
            row_store_ff[i] <= '0;
         end
      end else begin
         block_width_ff  <= block_width_in;
         block_height_ff <= block_height_in;
         half_pel_ff     <= half_pel_in;
         average_ff      <= average_in;
         left_ff         <= left_in;
         above_left_ff   <= above_left_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (accept) begin
            row_store_ff[col_idx] <= cur_pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_taps_ff  <= s1_taps_in;
      s1_dest_ff  <= s1_dest_in;
      s1_last_ff  <= s1_last_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `HPMC_ASSERT_NOW(a_col_in_window, clock, reset, 1'b1, col_ff < win_w)
   `HPMC_ASSERT_NEXT(a_tap_stage_holds, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff)
   `HPMC_ASSERT_NEXT(a_wrap_after_last, clock, reset,
      accept && col_end && row_end && !cfg_wr, (col_ff == '0) && (row_ff == '0))

endmodule

// ===== tb/half_pel_motion_comp_checker.sv =====
`timescale 1ns / 1ps
// checker for half_pel_motion_comp_top: follows csr writes and accepted req items,
// predicts each prediction pixel and its block-end flag, compares them with rsp items
// depends on hpmc_pkg

module half_pel_motion_comp_checker
   import hpmc_pkg::*;
#(
   parameter int MAX_BLOCK_WIDTH  = 16,
   parameter int MAX_BLOCK_HEIGHT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // ref_pixel, dest_pixel
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // pred_pixel
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          pending_count,
   output int          pixel_count,
   output int          pred_count
);

   localparam int LINE_DEPTH   = MAX_BLOCK_WIDTH + 1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } pred_type;

   pred_type         expected_preds[$];
   pred_type         oldest_pred;
   logic [4:0]       width_reg;
   logic [4:0]       height_reg;
   logic [1:0]       mode_reg;
   logic             average_reg;
   logic [PIX_W-1:0] line_buf [LINE_DEPTH];
   logic [PIX_W-1:0] left_pix;
   logic [PIX_W-1:0] above_left_pix;
   int               col_pos;
   int               row_pos;

   function automatic int fit_size(input int size, input int limit);
      return (size < 1) ? 1 : ((size > limit) ? limit : size);
   endfunction

   task automatic predict_pixel(input logic [PIX_W-1:0] cur, input logic [PIX_W-1:0] dest);
      int               hx;
      int               hy;
      int               win_w;
      int               win_h;
      int               idx;
      logic [9:0]       sum;
      logic [PIX_W-1:0] above;
      pred_type         pred;
      hx    = int'(mode_reg[0]);
      hy    = int'(mode_reg[1]);
      win_w = fit_size(int'(width_reg), MAX_BLOCK_WIDTH) + hx;
      win_h = fit_size(int'(height_reg), MAX_BLOCK_HEIGHT) + hy;
      idx   = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
      above = line_buf[idx];
      if (col_pos >= hx && row_pos >= hy) begin
         case (mode_reg)
            MODE_COPY: sum = {2'b00, cur};
            MODE_HORZ: sum = ({2'b00, left_pix} + {2'b00, cur} + 10'd1) >> 1;
            MODE_VERT: sum = ({2'b00, above} + {2'b00, cur} + 10'd1) >> 1;
            default:   sum = ({2'b00, above_left_pix} + {2'b00, above}
                              + {2'b00, left_pix} + {2'b00, cur} + 10'd2) >> 2;
         endcase
         if (average_reg) begin
            sum = (sum + {2'b00, dest} + 10'd1) >> 1;
         end
         pred.pixel = sum[PIX_W-1:0];
         pred.last  = (col_pos + 1 >= win_w) && (row_pos + 1 >= win_h);
         expected_preds.push_back(pred);
      end
      above_left_pix = above;
      line_buf[idx]  = cur;
      left_pix       = cur;
      if (col_pos + 1 >= win_w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= win_h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg      = BLOCK_WIDTH_RESET;
         height_reg     = BLOCK_HEIGHT_RESET;
         mode_reg       = MODE_COPY;
         average_reg    = 1'b0;
         left_pix       = '0;
         above_left_pix = '0;
         col_pos        = 0;
         row_pos        = 0;
         foreach (line_buf[i]) line_buf[i] = '0;
         expected_preds.delete();
         error_count    = 0;
         pixel_count    = 0;
         pred_count     = 0;
         pending_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_preds.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("unexpected result: pixel %0d last %0b", rsp_tdata, rsp_tlast);
               end
            end else begin
               oldest_pred = expected_preds.pop_front();
               pred_count++;
               if (rsp_tdata !== oldest_pred.pixel || rsp_tlast !== oldest_pred.last) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("mismatch at result %0d: expected pixel %0d last %0b, got %0d last %0b",
                              pred_count, oldest_pred.pixel, oldest_pred.last,
                              rsp_tdata, rsp_tlast);
                  end
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_BLOCK_WIDTH:  width_reg   = csr_pwdata[4:0];
               REG_BLOCK_HEIGHT: height_reg  = csr_pwdata[4:0];
               REG_HALF_PEL:     mode_reg    = csr_pwdata[1:0];
               REG_AVERAGE:      average_reg = csr_pwdata[0];
               default: ;
            endcase
            // geometry or mode change restarts the window, line store kept
            if (csr_paddr[3:2] != REG_AVERAGE) begin
               col_pos = 0;
               row_pos = 0;
            end
         end
         if (req_tvalid && req_tready) begin
            pixel_count++;
            predict_pixel(req_tdata[7:0], req_tdata[15:8]);
         end
         pending_count <= expected_preds.size();
      end
   end

endmodule

// ===== tb/half_pel_motion_comp_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for half_pel_motion_comp_top: drives reference windows and csr settings
// with random idling on both sides; checking is done in half_pel_motion_comp_checker
// depends on hpmc_pkg, half_pel_motion_comp_top and half_pel_motion_comp_checker

module half_pel_motion_comp_top_tb;
   import hpmc_pkg::*;

   localparam int MAX_W         = 16;
   localparam int MAX_H         = 16;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int RANDOM_PIXELS = 1250;
   localparam int DRAIN_CYCLES  = 8;
   localparam int IDLE_PERCENT  = 18;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int error_count;
   int pending_count;
   int pixel_count;
   int pred_count;
   int cycle_count   = 0;
   int setting_count = 0;
   int random_pixels = 0;
   bit steady        = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   half_pel_motion_comp_top #(
      .MAX_BLOCK_WIDTH  (MAX_W),
      .MAX_BLOCK_HEIGHT (MAX_H)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   half_pel_motion_comp_checker #(
      .MAX_BLOCK_WIDTH  (MAX_W),
      .MAX_BLOCK_HEIGHT (MAX_H)
   ) pred_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_count (pending_count),
      .pixel_count   (pixel_count),
      .pred_count    (pred_count)
   );

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("half_pel_motion_comp_top_tb: done, errors");
         $finish;
      end
   end

   function automatic int window_pixels(input int w, input int h, input logic [1:0] mode);
      int fw;
      int fh;
      fw = (w < 1) ? 1 : ((w > MAX_W) ? MAX_W : w);
      fh = (h < 1) ? 1 : ((h > MAX_H) ? MAX_H : h);
      return (fw + int'(mode[0])) * (fh + int'(mode[1]));
   endfunction

   task automatic send_pixel(input logic [7:0] ref_pix, input logic [7:0] dest_pix);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dest_pix, ref_pix};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   // wait until every predicted pixel is back and the pipeline is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [4:0] w, input logic [4:0] h,
                                input logic [1:0] mode, input logic avg);
      settle();
      write_reg(REG_BLOCK_WIDTH, 32'(w));
      write_reg(REG_BLOCK_HEIGHT, 32'(h));
      write_reg(REG_HALF_PEL, 32'(mode));
      write_reg(REG_AVERAGE, 32'(avg));
      setting_count++;
   endtask

   initial begin
      logic [4:0] w;
      logic [4:0] h;
      logic [1:0] mode;
      logic       avg;
      int         pixels;
      int         part;
      int         phase;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sizes below range clamp to one pixel
      apply_setting(5'd0, 5'd0, MODE_COPY, 1'b0);
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd255, 8'd255);
      apply_setting(5'd0, 5'd0, MODE_BOTH, 1'b0);
      repeat (4) send_pixel(8'd255, 8'd0);
      apply_setting(5'd0, 5'd0, MODE_BOTH, 1'b1);
      repeat (4) send_pixel(8'd0, 8'd255);
      apply_setting(5'd1, 5'd1, MODE_HORZ, 1'b0);
      send_pixel(8'd255, 8'd0);
      send_pixel(8'd0, 8'd0);
      apply_setting(5'd1, 5'd1, MODE_VERT, 1'b0);
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd255, 8'd0);
      // average turned on part way through a block, no restart
      apply_setting(5'd2, 5'd2, MODE_COPY, 1'b0);
      send_pixel(8'd255, 8'd0);
      send_pixel(8'd1, 8'd0);
      settle();
      write_reg(REG_AVERAGE, 32'd1);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd0, 8'd255);
      // mode rewrite in the first row restarts the window
      apply_setting(5'd1, 5'd1, MODE_BOTH, 1'b0);
      send_pixel(8'd200, 8'd0);
      settle();
      write_reg(REG_HALF_PEL, 32'(MODE_BOTH));
      send_random(4);

      phase = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if (phase == 0) begin
            w = 5'd31;
            h = 5'd31;
            mode = MODE_BOTH;
         end else if (phase == 1) begin
            w = 5'd8;
            h = 5'd4;
            mode = 2'($urandom_range(3));
         end else begin
            if ($urandom_range(9) == 0) begin
               w = 5'($urandom_range(31));
            end else begin
               w = $urandom_range(1) ? 5'd16 : 5'd8;
            end
            if ($urandom_range(9) == 0) begin
               h = 5'($urandom_range(31));
            end else begin
               case ($urandom_range(2))
                  0:       h = 5'd4;
                  1:       h = 5'd8;
                  default: h = 5'd16;
               endcase
            end
            mode = 2'($urandom_range(3));
         end
         avg = 1'($urandom_range(1));
         apply_setting(w, h, mode, avg);
         pixels = window_pixels(int'(w), int'(h), mode);
         repeat ($urandom_range(1, 3)) begin
            steady = (random_pixels >= 500 && random_pixels < 800);
            if (pixels > 1 && $urandom_range(5) == 0) begin
               part = $urandom_range(1, pixels - 1);
               send_random(part);
               settle();
               avg = !avg;
               write_reg(REG_AVERAGE, 32'(avg));
               send_random(pixels - part);
            end else begin
               send_random(pixels);
            end
            random_pixels += pixels;
         end
         // cut a block short, the next setting restarts the window
         if (pixels > 1 && $urandom_range(7) == 0) begin
            part = $urandom_range(1, pixels - 1);
            send_random(part);
            random_pixels += part;
         end
         phase++;
      end
      steady = 1'b0;

      settle();
      $display("sent %0d pixels over %0d settings, %0d prediction pixels checked",
               pixel_count, setting_count, pred_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("half_pel_motion_comp_top_tb: done, clean");
      end else begin
         $display("half_pel_motion_comp_top_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hpmc_pkg.sv
rtl/hpmc_interp.sv
rtl/half_pel_motion_comp_top.sv
tb/half_pel_motion_comp_checker.sv
tb/half_pel_motion_comp_top_tb.sv
